// ----- sv/bcfr_pkg.sv -----
// Package for the BLE command frame receiver: transaction payload types,
// opcode and status codes, and frame header constants.
// No dependencies.
package bcfr_pkg;

  // Opcodes carried in an input transaction
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_TAKEN      = 3'd0;
  localparam logic [2:0] ST_COMPLETE   = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_BAD_CLASS  = 3'd4;
  localparam logic [2:0] ST_LOST       = 3'd5;
  localparam logic [2:0] ST_OTHER      = 3'd6;

  // Frame format
  localparam logic [7:0] HDR_EVENT    = 8'h80;
  localparam logic [7:0] HDR_RESPONSE = 8'h00;
  localparam logic [7:0] CLASS_MAX    = 8'h07;
  localparam logic [8:0] LEN_OVERHEAD = 9'd4;
  localparam logic [5:0] MAX_LEN_RESET = 6'd30;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic       response_pending;
    logic [4:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       frame_ready;
    logic [5:0] frame_length;
    logic [7:0] read_data;
    logic [7:0] lost_frame_total;
    logic [7:0] lost_byte_total;
  } out_item_t;

  // Write port from the parser into the frame store; the position covers
  // any frame length the 6-bit limit allows
  typedef struct packed {
    logic       en;
    logic [5:0] pos;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ----- sv/bcfr_frame_store.sv -----
// Frame byte store: one write port from the parser, one registered read port.
// Depends on bcfr_pkg.
module bcfr_frame_store import bcfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  store_wr_t  wr,
  input  logic       rd_en,
  input  logic [4:0] rd_index,
  output logic [7:0] rd_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];

  logic [8:0]    wr_pos9;
  logic [8:0]    rd_idx9;
  logic          wr_hit;
  logic          rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_pos9     = {3'b0, wr.pos};
  assign rd_idx9     = {4'b0, rd_index};
  assign wr_hit      = wr.en && (wr_pos9 < DEPTH9);
  assign rd_in_range = rd_idx9 < DEPTH9;
  assign wr_addr     = wr_pos9[AW-1:0];
  assign rd_addr     = rd_idx9[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // Forward a byte written at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (!rd_in_range) begin
        rd_data <= 8'd0;
      end else if (wr_hit && (wr_addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- sv/bcfr_parser.sv -----
// Frame parser: header, length and class checks, frame state and counters.
// Depends on bcfr_pkg.
module bcfr_parser import bcfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_item_t   item,
  input  logic [5:0] max_len,
  input  logic [7:0] rd_data,
  output out_item_t  result,
  output store_wr_t  wr
);

  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  logic [5:0] byte_position, byte_position_next;
  logic [5:0] expected_length, expected_length_next;
  logic       ready_flag, ready_flag_next;
  logic [7:0] dropped_frames, dropped_frames_next;
  logic [7:0] dropped_bytes, dropped_bytes_next;

  logic [8:0] limit9;
  logic [8:0] total9;
  logic [5:0] pos_inc;
  logic [2:0] status;

  assign limit9  = ({3'b0, max_len} > DEPTH9) ? DEPTH9 : {3'b0, max_len};
  assign total9  = {1'b0, item.rx_byte} + LEN_OVERHEAD;
  assign pos_inc = byte_position + 6'd1;

  always_comb begin
    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    ready_flag_next      = ready_flag;
    dropped_frames_next  = dropped_frames;
    dropped_bytes_next   = dropped_bytes;
    status               = ST_OTHER;
    wr.en                = 1'b0;
    wr.pos               = byte_position;
    wr.data              = item.rx_byte;
    case (item.opcode)
      OP_RX_BYTE: begin
        if (ready_flag) begin
          dropped_bytes_next = dropped_bytes + 8'd1;
          status             = ST_LOST;
        end else begin
          wr.en  = 1'b1;
          status = ST_TAKEN;
          case (byte_position)
            6'd0: begin
              byte_position_next = 6'd1;
              if (!(item.rx_byte == HDR_EVENT ||
                    (item.rx_byte == HDR_RESPONSE && item.response_pending))) begin
                dropped_frames_next = dropped_frames + 8'd1;
                byte_position_next  = 6'd0;
                status              = ST_BAD_HEADER;
              end
            end
            6'd1: begin
              byte_position_next = 6'd2;
              if (total9 > limit9) begin
                expected_length_next = 6'd0;
                dropped_frames_next  = dropped_frames + 8'd1;
                byte_position_next   = 6'd0;
                status               = ST_TOO_LONG;
              end else begin
                expected_length_next = total9[5:0];
              end
            end
            6'd2: begin
              byte_position_next = 6'd3;
              if (item.rx_byte > CLASS_MAX) begin
                dropped_frames_next = dropped_frames + 8'd1;
                byte_position_next  = 6'd0;
                status              = ST_BAD_CLASS;
              end
            end
            default: begin
              if (pos_inc >= expected_length) begin
                ready_flag_next    = 1'b1;
                byte_position_next = 6'd0;
                status             = ST_COMPLETE;
              end else begin
                byte_position_next = pos_inc;
              end
            end
          endcase
        end
      end
      OP_RELEASE: begin
        ready_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
    if (!advance) begin
      wr.en = 1'b0;
    end
  end

  always_comb begin
    result.status           = status;
    result.frame_ready      = ready_flag_next;
    result.frame_length     = expected_length_next;
    result.read_data        = (item.opcode == OP_READ) ? rd_data : 8'd0;
    result.lost_frame_total = dropped_frames_next;
    result.lost_byte_total  = dropped_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 6'd0;
      expected_length <= 6'd0;
      ready_flag      <= 1'b0;
      dropped_frames  <= 8'd0;
      dropped_bytes   <= 8'd0;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      expected_length <= expected_length_next;
      ready_flag      <= ready_flag_next;
      dropped_frames  <= dropped_frames_next;
      dropped_bytes   <= dropped_bytes_next;
    end
  end

endmodule

// ----- sv/ble_command_frame_receiver.sv -----
// BLE command frame receiver, top level. Depends on bcfr_pkg, bcfr_frame_store, bcfr_parser.
// Path: an input transaction passes the input register, then the result register.
// Throughput: 1 transaction per cycle while out_ready takes each result; the parser itself is combinational.
// Reset (rst, synchronous): clears valids, frame state and counters; limit back to 30.
// The frame store has no reset; only bytes written since power-up are meaningful.
module ble_command_frame_receiver import bcfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [5:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  // Frame length limit register
  logic [5:0] max_len;

  // Input stage
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_advance;
  logic      in_accept;

  out_item_t result;
  store_wr_t wr;
  logic [7:0] rd_data;

  // Advance the input stage whenever the result register is free or draining,
  // so a result that is being taken does not block the next transaction.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write_en) begin
      max_len <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the payload; it is only looked at while s1_valid is set
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_data;
    end
  end

  // Store read is issued at acceptance so the byte is ready in the input stage;
  // a byte written by the item ahead at the same edge is forwarded.
  bcfr_frame_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_en    (in_accept),
    .rd_index (in_data.read_index),
    .rd_data  (rd_data)
  );

  bcfr_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .item    (s1_item),
    .max_len (max_len),
    .rd_data (rd_data),
    .result  (result),
    .wr      (wr)
  );

  // Result register: load on advance, drop valid once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result;
    end
  end

endmodule

// ----- sv/bcfr_checker.sv -----
// Port-level checker for the BLE command frame receiver, bound to the top level.
// Depends on bcfr_pkg.
module bcfr_checker import bcfr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Bytes are only lost while a frame waits
  a_lost_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_LOST |-> out_data.frame_ready)
    else $error("byte lost without a ready frame");

  // A completed frame is flagged ready
  a_complete_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_COMPLETE |-> out_data.frame_ready)
    else $error("frame complete without ready");

  // A too-long frame clears the length
  a_too_long_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_TOO_LONG |-> out_data.frame_length == 6'd0)
    else $error("too-long frame left a length");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ble_command_frame_receiver bcfr_checker u_bcfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
